// File: rtl/dual_mode_timer_counter_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef DUAL_MODE_TIMER_COUNTER_UNIT_DEFINES_SVH
`define DUAL_MODE_TIMER_COUNTER_UNIT_DEFINES_SVH

// Checked at every clock edge, quiet while reset is applied.
`define DMTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define DMTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/dmtc_pkg.sv
package dmtc_pkg;

  // Command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Register select codes
  localparam logic [2:0] SEL_LOW0  = 3'd0;
  localparam logic [2:0] SEL_HIGH0 = 3'd1;
  localparam logic [2:0] SEL_LOW1  = 3'd2;
  localparam logic [2:0] SEL_HIGH1 = 3'd3;
  localparam logic [2:0] SEL_CTRL  = 3'd4;

  // Timer modes
  localparam logic [1:0] MODE_13BIT  = 2'd0;
  localparam logic [1:0] MODE_16BIT  = 2'd1;
  localparam logic [1:0] MODE_RELOAD = 2'd2;
  localparam logic [1:0] MODE_SPLIT  = 2'd3;  // timer 0 split, timer 1 stopped

  // Control byte bit positions
  localparam int unsigned RUN0_BIT  = 4;
  localparam int unsigned FLAG0_BIT = 5;
  localparam int unsigned RUN1_BIT  = 6;
  localparam int unsigned FLAG1_BIT = 7;

  // APB configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_TIMER0_MODE = 3'd0;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] register_select;
    logic [7:0] write_data;
  } dmtc_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer0_overflow;
    logic       timer1_overflow;
    logic       flag0;
    logic       flag1;
  } dmtc_out_t;

  typedef struct packed {
    logic [1:0] timer1_mode;
    logic [1:0] timer0_mode;
  } dmtc_mode_t;

endpackage

// File: rtl/dmtc_regs.sv
module dmtc_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dmtc_pkg::PADDR_W-1:0] paddr,
  input  logic [dmtc_pkg::PDATA_W-1:0] pwdata,
  output logic [dmtc_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output dmtc_pkg::dmtc_mode_t         mode_o
);
  import dmtc_pkg::*;

  logic [1:0] mode0_q, mode1_q;
  logic       wr_en;
  logic       sel_t1;

  // Register index comes from the word address bit
  assign sel_t1 = paddr[2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  // Mode registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode0_q <= MODE_13BIT;
      mode1_q <= MODE_13BIT;
    end else if (wr_en) begin
      if (sel_t1) begin
        mode1_q <= pwdata[1:0];
      end else begin
        mode0_q <= pwdata[1:0];
      end
    end
  end

  // Read back
  assign prdata = {{(PDATA_W-2){1'b0}}, (sel_t1 ? mode1_q : mode0_q)};

  assign mode_o.timer0_mode = mode0_q;
  assign mode_o.timer1_mode = mode1_q;

endmodule

// File: rtl/dmtc_core.sv
module dmtc_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_en_i,
  input  dmtc_pkg::dmtc_in_t   item_i,
  input  dmtc_pkg::dmtc_mode_t mode_i,
  output dmtc_pkg::dmtc_out_t  result_o
);
  import dmtc_pkg::*;

  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] hi;
    logic       ovf;
  } step_t;

  // One count of a non-split timer
  function automatic step_t timer_step(logic [1:0] mode, logic [7:0] lo, logic [7:0] hi);
    step_t      r;
    logic [12:0] v13;
    logic [15:0] v16;
    r.lo  = lo;
    r.hi  = hi;
    r.ovf = 1'b0;
    v13   = {hi, lo[4:0]} + 13'd1;
    v16   = {hi, lo} + 16'd1;
    case (mode)
      MODE_13BIT: begin
        r.lo  = {lo[7:5], v13[4:0]};
        r.hi  = v13[12:5];
        r.ovf = &{hi, lo[4:0]};
      end
      MODE_16BIT: begin
        r.lo  = v16[7:0];
        r.hi  = v16[15:8];
        r.ovf = &{hi, lo};
      end
      MODE_RELOAD: begin
        r.ovf = &lo;
        r.lo  = r.ovf ? hi : lo + 8'd1;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  logic [7:0] lo0_q, hi0_q, lo1_q, hi1_q, ctrl_q;
  logic [7:0] lo0_d, hi0_d, lo1_d, hi1_d, ctrl_d;
  logic [7:0] rd;
  logic       ovf0, ovf1;
  step_t      adv0, adv1;

  assign adv0 = timer_step(mode_i.timer0_mode, lo0_q, hi0_q);
  assign adv1 = timer_step(mode_i.timer1_mode, lo1_q, hi1_q);

  // Next state and result for the item in the input register
  always_comb begin
    lo0_d  = lo0_q;
    hi0_d  = hi0_q;
    lo1_d  = lo1_q;
    hi1_d  = hi1_q;
    ctrl_d = ctrl_q;
    rd     = 8'd0;
    ovf0   = 1'b0;
    ovf1   = 1'b0;
    case (item_i.command)
      CMD_TICK: begin
        // timer 0 first
        if (mode_i.timer0_mode == MODE_SPLIT) begin
          if (ctrl_q[RUN0_BIT]) begin
            lo0_d = lo0_q + 8'd1;
            ovf0  = &lo0_q;
          end
          // high half runs on run 1 and reports through flag 1
          if (ctrl_q[RUN1_BIT]) begin
            hi0_d = hi0_q + 8'd1;
            if (&hi0_q) begin
              ctrl_d[FLAG1_BIT] = 1'b1;
            end
          end
        end else if (ctrl_q[RUN0_BIT]) begin
          lo0_d = adv0.lo;
          hi0_d = adv0.hi;
          ovf0  = adv0.ovf;
        end
        if (ovf0) begin
          ctrl_d[FLAG0_BIT] = 1'b1;
        end
        // then timer 1
        if (mode_i.timer1_mode != MODE_SPLIT && ctrl_q[RUN1_BIT]) begin
          lo1_d = adv1.lo;
          hi1_d = adv1.hi;
          ovf1  = adv1.ovf;
        end
        if (ovf1) begin
          ctrl_d[FLAG1_BIT] = 1'b1;
        end
      end
      CMD_WRITE: begin
        case (item_i.register_select)
          SEL_LOW0:  lo0_d  = item_i.write_data;
          SEL_HIGH0: hi0_d  = item_i.write_data;
          SEL_LOW1:  lo1_d  = item_i.write_data;
          SEL_HIGH1: hi1_d  = item_i.write_data;
          SEL_CTRL:  ctrl_d = item_i.write_data;
          default: begin
          end
        endcase
      end
      CMD_READ: begin
        case (item_i.register_select)
          SEL_LOW0:  rd = lo0_q;
          SEL_HIGH0: rd = hi0_q;
          SEL_LOW1:  rd = lo1_q;
          SEL_HIGH1: rd = hi1_q;
          SEL_CTRL:  rd = ctrl_q;
          default:   rd = 8'd0;
        endcase
      end
      default: begin
      end
    endcase
  end

  assign result_o.read_data       = rd;
  assign result_o.timer0_overflow = ovf0;
  assign result_o.timer1_overflow = ovf1;
  assign result_o.flag0           = ctrl_d[FLAG0_BIT];
  assign result_o.flag1           = ctrl_d[FLAG1_BIT];

  // Timer state, updated as the item passes to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo0_q  <= 8'd0;
      hi0_q  <= 8'd0;
      lo1_q  <= 8'd0;
      hi1_q  <= 8'd0;
      ctrl_q <= 8'd0;
    end else if (step_en_i) begin
      lo0_q  <= lo0_d;
      hi0_q  <= hi0_d;
      lo1_q  <= lo1_d;
      hi1_q  <= hi1_d;
      ctrl_q <= ctrl_d;
    end
  end

endmodule

// File: rtl/dual_mode_timer_counter_unit.sv
// Channel   Direction  Handshake              Word
// input     in         in_valid_i/in_stall_o  dmtc_in_t  (command, register_select, write_data)
// output    out        out_valid_o/out_stall_i dmtc_out_t (read_data, overflows, flags)
// config    in/out     APB psel/penable/pready timer0_mode @0x0, timer1_mode @0x4
//
// One word per cycle sustained while the output is not stalled.
// The input register feeds the timer update logic, whose result lands in the output register.
// Reset clears the timer state, the mode registers and both valid bits.
// A stalled output holds its word; the input register still takes one word while it is empty.
module dual_mode_timer_counter_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  dmtc_pkg::dmtc_in_t           in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output dmtc_pkg::dmtc_out_t          out_word_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dmtc_pkg::PADDR_W-1:0] paddr,
  input  logic [dmtc_pkg::PDATA_W-1:0] pwdata,
  output logic [dmtc_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import dmtc_pkg::*;

  dmtc_mode_t mode;
  dmtc_in_t   in_q;
  dmtc_out_t  out_q, result;
  logic       in_valid_q, out_valid_q;
  logic       advance, in_take;

  // Move the held word on when the output register is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  dmtc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode_o  (mode)
  );

  dmtc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .item_i    (in_q),
    .mode_i    (mode),
    .result_o  (result)
  );

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_word_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// File: rtl/dmtc_checker.sv
`include "dual_mode_timer_counter_unit_defines.svh"

module dmtc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input dmtc_pkg::dmtc_out_t out_word_o
);
  import dmtc_pkg::*;

  // A stalled result word stays put
  `DMTC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o), "output word changed under stall")

  // No result during reset
  `DMTC_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_valid_o, "output valid during reset")

  // An overflow always leaves its flag set
  `DMTC_ASSERT(a_ovf0_flag, out_valid_o |-> (!out_word_o.timer0_overflow || out_word_o.flag0), "timer 0 overflow without flag 0")

  `DMTC_ASSERT(a_ovf1_flag, out_valid_o |-> (!out_word_o.timer1_overflow || out_word_o.flag1), "timer 1 overflow without flag 1")

endmodule

bind dual_mode_timer_counter_unit dmtc_checker u_checker (.*);
